/* sv/bts_pkg.sv */
package bts_pkg;

   // Default texture size limits
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   // Catmull-Rom weight width (scaled by 2^25, signed)
   localparam int WW = 28;

   // Command queue depth between front and back
   localparam int QDEPTH = 2;

   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_TEX_WIDTH    = 3'd0,
      CSR_TEX_HEIGHT   = 3'd1,
      CSR_WIDE_TEXELS  = 3'd2,
      CSR_RESOLUTION   = 3'd3,
      CSR_HORIZ_ANCHOR = 3'd4,
      CSR_VERT_ANCHOR  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ANC_NEAR = 2'd0,
      ANC_MID  = 2'd1,
      ANC_FAR  = 2'd2
   } anchor_type;

   typedef struct packed {
      logic [8:0]  tex_width;
      logic [8:0]  tex_height;
      logic        wide_texels;
      logic [15:0] resolution;
      logic [1:0]  horiz_anchor;
      logic [1:0]  vert_anchor;
   } csr_type;

   // One queued job: a texel write or a fully mapped sample
   typedef struct packed {
      cmd_type              cmd;
      logic [15:0]          texel_index;
      logic [15:0]          texel_value;
      logic [3:0][15:0]     col;
      logic [3:0][15:0]     row_base;
      logic [3:0][WW-1:0]   wx;
      logic [3:0][WW-1:0]   wy;
   } job_type;

endpackage

/* sv/bts_queue.sv */
module bts_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bts_pkg::job_type push_job,
   input  logic             pop,
   output bts_pkg::job_type head_job,
   output logic             full,
   output logic             empty
);

   localparam int PW = (bts_pkg::QDEPTH > 1) ? $clog2(bts_pkg::QDEPTH) : 1;
   localparam int CW = $clog2(bts_pkg::QDEPTH + 1);

   bts_pkg::job_type  slot_ff [bts_pkg::QDEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign full     = (count_ff == CW'(bts_pkg::QDEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = slot_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(bts_pkg::QDEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(bts_pkg::QDEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold request payloads
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* sv/bts_front.sv */
module bts_front #(
   parameter int MAX_WIDTH  = bts_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bts_pkg::MAX_HEIGHT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  bts_pkg::csr_type csr,
   input  logic             start,
   output logic             busy,
   input  logic             req_command,
   input  logic [15:0]      req_texel_index,
   input  logic [15:0]      req_texel_value,
   input  logic [23:0]      req_sample_x,
   input  logic [23:0]      req_sample_y,
   output logic             push,
   output bts_pkg::job_type push_job,
   input  logic             full
);

   localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int SW   = $clog2(MAXD + 1);
   localparam int EW   = (SW > 9) ? SW : 9;
   localparam int NW   = SW + 16;
   localparam int CNW  = $clog2(SW);
   localparam int VW   = 19;
   localparam int WW   = bts_pkg::WW;

   typedef enum logic [7:0] {
      F_IDLE = 8'b00000001,
      F_MAP  = 8'b00000010,
      F_DIV  = 8'b00000100,
      F_BASE = 8'b00001000,
      F_WGT1 = 8'b00010000,
      F_WGT2 = 8'b00100000,
      F_WGT3 = 8'b01000000,
      F_PUSH = 8'b10000000
   } fstate_type;

   fstate_type          state_ff, state_in;
   logic [15:0]         dx_ff, dy_ff;
   logic [7:0]          fx_ff, fy_ff;
   logic [2:0]          k_ff, k_in;
   logic [NW-1:0]       num_ff, num_in;
   logic [NW-1:0]       den_ff, den_in;
   logic [SW-1:0]       quo_ff, quo_in;
   logic [CNW-1:0]      cnt_ff, cnt_in;
   logic [SW-1:0]       px_ff [4];
   logic [SW-1:0]       py_ff [4];
   logic [15:0]         base_ff [4];
   logic [15:0]         f2x_ff, f2y_ff;
   logic [23:0]         f3x_ff, f3y_ff;
   logic [3:0][WW-1:0]  wx_ff, wy_ff;

   logic                accept;
   logic [EW-1:0]       wext, hext;
   logic [SW-1:0]       sw, sh, s_cur;
   logic [15:0]         d_cur;
   logic [1:0]          anc;
   logic signed [VW-1:0] c, v, s_ext, smax, rext;
   logic                direct;
   logic [SW-1:0]       p_direct;
   logic                store;
   logic [SW-1:0]       p_store;
   logic                quo_bit;
   logic [NW-1:0]       num_sub;
   logic [2*SW-1:0]     bprod;

   assign accept = start && !busy;
   assign busy   = (state_ff != F_IDLE) || full;

   // Saturate the size registers to the supported range
   assign wext = EW'(csr.tex_width);
   assign hext = EW'(csr.tex_height);
   always_comb begin
      if (wext == '0) begin
         sw = SW'(1);
      end else if (wext > EW'(MAX_WIDTH)) begin
         sw = SW'(MAX_WIDTH);
      end else begin
         sw = SW'(wext);
      end
      if (hext == '0) begin
         sh = SW'(1);
      end else if (hext > EW'(MAX_HEIGHT)) begin
         sh = SW'(MAX_HEIGHT);
      end else begin
         sh = SW'(hext);
      end
   end

   // Anchor the current tap coordinate (x taps first, then y taps)
   assign s_cur = k_ff[2] ? sh : sw;
   assign d_cur = k_ff[2] ? dy_ff : dx_ff;
   assign anc   = k_ff[2] ? csr.vert_anchor : csr.horiz_anchor;
   assign c     = VW'(d_cur) + VW'(k_ff[1:0]) - VW'(1);
   assign s_ext = VW'(s_cur);
   assign smax  = s_ext - VW'(1);
   assign rext  = VW'(csr.resolution);

   always_comb begin
      unique case (anc)
         bts_pkg::ANC_MID: v = c + VW'(s_cur >> 1);
         bts_pkg::ANC_FAR: v = s_ext - c;
         default:          v = c;
      endcase
   end

   // Decide whether the tap needs the divider
   always_comb begin
      direct   = 1'b1;
      p_direct = '0;
      if (csr.resolution == '0) begin
         if (v < 0) begin
            p_direct = '0;
         end else if (v > smax) begin
            p_direct = s_cur - SW'(1);
         end else begin
            p_direct = v[SW-1:0];
         end
      end else if (v <= 0) begin
         p_direct = '0;
      end else if (v >= rext) begin
         p_direct = s_cur - SW'(1);
      end else begin
         direct = 1'b0;
      end
   end

   // One restoring divide step: quotient stays below the axis size
   assign quo_bit = (num_ff >= den_ff);
   assign num_sub = num_ff - den_ff;
   assign bprod   = (2*SW)'(py_ff[k_ff[1:0]]) * (2*SW)'(sw);

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      store    = 1'b0;
      p_store  = p_direct;
      unique case (state_ff)
         F_IDLE: begin
            if (accept && (req_command == bts_pkg::CMD_SAMPLE)) begin
               k_in     = '0;
               state_in = F_MAP;
            end
         end
         F_MAP: begin
            if (direct) begin
               store = 1'b1;
            end else begin
               num_in   = NW'(s_cur) * NW'(v[15:0]);
               den_in   = NW'(csr.resolution) << (SW - 1);
               quo_in   = '0;
               cnt_in   = CNW'(SW - 1);
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            if (quo_bit) begin
               num_in = num_sub;
            end
            den_in = den_ff >> 1;
            quo_in = {quo_ff[SW-2:0], quo_bit};
            cnt_in = cnt_ff - CNW'(1);
            if (cnt_ff == '0) begin
               store   = 1'b1;
               p_store = {quo_ff[SW-2:0], quo_bit};
            end
         end
         F_BASE: begin
            k_in = k_ff + 3'd1;
            if (k_ff[1:0] == 2'd3) begin
               state_in = F_WGT1;
            end
         end
         F_WGT1: state_in = F_WGT2;
         F_WGT2: state_in = F_WGT3;
         F_WGT3: state_in = F_PUSH;
         F_PUSH: begin
            if (!full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
      if (store) begin
         if (k_ff == 3'd7) begin
            k_in     = '0;
            state_in = F_BASE;
         end else begin
            k_in     = k_ff + 3'd1;
            state_in = F_MAP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         k_ff     <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Hold sample coordinates and mapped taps
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      if (state_ff == F_IDLE && accept) begin
         dx_ff <= req_sample_x[23:8];
         dy_ff <= req_sample_y[23:8];
         fx_ff <= req_sample_x[7:0];
         fy_ff <= req_sample_y[7:0];
      end
      if (store) begin
         if (k_ff[2]) begin
            py_ff[k_ff[1:0]] <= p_store;
         end else begin
            px_ff[k_ff[1:0]] <= p_store;
         end
      end
      if (state_ff == F_BASE) begin
         base_ff[k_ff[1:0]] <= 16'(bprod);
      end
      if (state_ff == F_WGT1) begin
         f2x_ff <= 16'(fx_ff) * 16'(fx_ff);
         f2y_ff <= 16'(fy_ff) * 16'(fy_ff);
      end
      if (state_ff == F_WGT2) begin
         f3x_ff <= 24'(f2x_ff) * 24'(fx_ff);
         f3y_ff <= 24'(f2y_ff) * 24'(fy_ff);
      end
      if (state_ff == F_WGT3) begin
         wx_ff <= cr_weights(fx_ff, f2x_ff, f3x_ff);
         wy_ff <= cr_weights(fy_ff, f2y_ff, f3y_ff);
      end
   end

   // Catmull-Rom weights scaled by 2^25, built from shifts and adds
   function automatic logic [3:0][WW-1:0] cr_weights(
      input logic [7:0]  f,
      input logic [15:0] f2,
      input logic [23:0] f3
   );
      logic signed [WW-1:0] a;
      logic signed [WW-1:0] b;
      logic signed [WW-1:0] t;
      logic [3:0][WW-1:0]   w;
      a = WW'(f);
      b = WW'(f2);
      t = WW'(f3);
      w[0] = -(a <<< 16) + (b <<< 9) - t;
      w[1] = (WW'(1) <<< 25) - ((b <<< 10) + (b <<< 8)) + ((t <<< 1) + t);
      w[2] = (a <<< 16) + (b <<< 10) - ((t <<< 1) + t);
      w[3] = -(b <<< 8) + t;
      return w;
   endfunction

   // Drive the queue: writes go straight in, samples once mapped
   assign push = (state_ff == F_IDLE && accept && req_command == bts_pkg::CMD_WRITE)
              || (state_ff == F_PUSH && !full);

   always_comb begin
      push_job             = '0;
      push_job.texel_index = req_texel_index;
      push_job.texel_value = req_texel_value;
      push_job.cmd         = bts_pkg::CMD_WRITE;
      if (state_ff == F_PUSH) begin
         push_job.cmd = bts_pkg::CMD_SAMPLE;
         for (int i = 0; i < 4; i++) begin
            push_job.col[i]      = 16'(px_ff[i]);
            push_job.row_base[i] = base_ff[i];
         end
         push_job.wx = wx_ff;
         push_job.wy = wy_ff;
      end
   end

endmodule

/* sv/bts_back.sv */
module bts_back (
   input  logic                clock,
   input  logic                reset,
   input  bts_pkg::csr_type    csr,
   input  bts_pkg::job_type    head_job,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   output logic signed [18:0]  rsp_sample_value
);

   localparam int WW   = bts_pkg::WW;
   localparam int HPW  = WW + 17;
   localparam int HW   = 47;
   localparam int QB   = 27;
   localparam int HQW  = QB + 1;
   localparam int YPW  = WW + HQW;
   localparam int VAW  = YPW + 2;
   localparam int RW   = VAW - 33;

   typedef enum logic [6:0] {
      B_IDLE = 7'b0000001,
      B_READ = 7'b0000010,
      B_MUL  = 7'b0000100,
      B_ACC  = 7'b0001000,
      B_DIV  = 7'b0010000,
      B_YMUL = 7'b0100000,
      B_YACC = 7'b1000000
   } bstate_type;

   logic [15:0]              mem [65536];
   bstate_type               state_ff, state_in;
   bts_pkg::job_type         job_ff;
   logic [1:0]               i_ff, i_in, j_ff, j_in;
   logic [15:0]              rdata_ff;
   logic signed [HPW-1:0]    hprod_ff;
   logic signed [HW-1:0]     hacc_ff, hacc_in;
   logic [HW-1:0]            rem_ff, rem_in;
   logic [QB-1:0]            quo_ff, quo_in;
   logic                     neg_ff, neg_in;
   logic signed [HQW-1:0]    h_ff;
   logic signed [YPW-1:0]    yprod_ff;
   logic signed [VAW-1:0]    vacc_ff, vacc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [18:0]       rsp_value_ff, rsp_value_in;

   logic [15:0]              rd_addr;
   logic [16:0]              texel;
   logic [16:0]              dnorm;
   logic signed [HW-1:0]     n_sum;
   logic [HW-1:0]            fold_hi, fold_lo;
   logic                     fold_done;
   logic [QB-1:0]            q_final;
   logic signed [RW-1:0]     r_val;

   assign pop = (state_ff == B_IDLE) && !empty;
   assign rd_addr = job_ff.col[j_ff] + job_ff.row_base[i_ff];
   assign texel = csr.wide_texels ? {1'b0, rdata_ff} : {9'b0, rdata_ff[7:0]};
   assign dnorm = csr.wide_texels ? 17'd65535 : 17'd255;
   assign n_sum = hacc_in + HW'(dnorm);
   assign r_val = RW'((vacc_in + (VAW'(1) <<< 32)) >>> 33);

   // Divide by D = 2^n-1: x = hi*D + (hi + lo), so fold hi into lo until hi is zero
   assign fold_hi   = csr.wide_texels ? (rem_ff >> 16) : (rem_ff >> 8);
   assign fold_lo   = csr.wide_texels ? {{(HW-16){1'b0}}, rem_ff[15:0]}
                                      : {{(HW-8){1'b0}}, rem_ff[7:0]};
   assign fold_done = (fold_hi == '0);
   assign q_final   = (rem_ff == HW'(dnorm)) ? quo_ff + QB'(1) : quo_ff;

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      hacc_in      = hacc_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      vacc_in      = vacc_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (pop && head_job.cmd == bts_pkg::CMD_SAMPLE) begin
               i_in     = '0;
               j_in     = '0;
               hacc_in  = '0;
               vacc_in  = '0;
               state_in = B_READ;
            end
         end
         B_READ: state_in = B_MUL;
         B_MUL:  state_in = B_ACC;
         B_ACC: begin
            hacc_in = hacc_ff + HW'(hprod_ff);
            if (j_ff == 2'd3) begin
               // Round to nearest over 2*D via floor((H + D) / 2D), halved first
               neg_in = n_sum < 0;
               if (n_sum < 0) begin
                  rem_in = (HW'(-n_sum) + HW'({dnorm, 1'b0}) - HW'(1)) >> 1;
               end else begin
                  rem_in = $unsigned(n_sum) >> 1;
               end
               quo_in   = '0;
               state_in = B_DIV;
            end else begin
               j_in     = j_ff + 2'd1;
               state_in = B_READ;
            end
         end
         B_DIV: begin
            if (fold_done) begin
               state_in = B_YMUL;
            end else begin
               quo_in = quo_ff + QB'(fold_hi);
               rem_in = fold_hi + fold_lo;
            end
         end
         B_YMUL: state_in = B_YACC;
         B_YACC: begin
            vacc_in = vacc_ff + VAW'(yprod_ff);
            if (i_ff == 2'd3) begin
               rsp_valid_in = 1'b1;
               if (r_val < -RW'(262144)) begin
                  rsp_value_in = 19'sh40000;
               end else if (r_val > RW'(262143)) begin
                  rsp_value_in = 19'sh3FFFF;
               end else begin
                  rsp_value_in = r_val[18:0];
               end
               state_in = B_IDLE;
            end else begin
               i_in     = i_ff + 2'd1;
               j_in     = '0;
               hacc_in  = '0;
               state_in = B_READ;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      hacc_ff      <= hacc_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      neg_ff       <= neg_in;
      vacc_ff      <= vacc_in;
      rsp_value_ff <= rsp_value_in;
      if (pop) begin
         job_ff <= head_job;
      end
      if (state_ff == B_MUL) begin
         hprod_ff <= HPW'($signed(job_ff.wx[j_ff])) * HPW'($signed(texel));
      end
      if (state_ff == B_DIV && fold_done) begin
         h_ff <= neg_ff ? -HQW'(q_final) : HQW'(q_final);
      end
      if (state_ff == B_YMUL) begin
         yprod_ff <= YPW'($signed(job_ff.wy[i_ff])) * YPW'(h_ff);
      end
   end

   // Texel store: write on a popped write request, registered read
   always_ff @(posedge clock) begin
      if (pop && head_job.cmd == bts_pkg::CMD_WRITE) begin
         mem[head_job.texel_index] <= head_job.texel_value;
      end
      if (state_ff == B_READ) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = rsp_value_ff;

endmodule

/* sv/bicubic_texture_sampler.sv */
// Channel   Ports                                   Handshake
// request   req_command, req_texel_index/value,     start high while busy low
//           req_sample_x, req_sample_y
// response  rsp_sample_value                        rsp_valid strobe, one cycle
// csr       csr_index, csr_wdata                    csr_valid and csr_ready
//
// A texel write is pushed into the queue in the cycle that it is accepted.
// A sample maps eight taps in the front, each directly or through the
// resolution divider, which yields SW quotient bits (SW = bits of the larger size limit),
// then forms the row bases and the weights and pushes the job into the queue.
// The back reads 16 texels through one memory port (read, multiply and
// accumulate for each) and divides each row sum by 2*D with shift-and-add
// folding. The slower side sets the sample rate.
// Synchronous reset returns both sides to idle and empties the queue;
// the texel store holds no reset value. The receiver cannot stall results.
module bicubic_texture_sampler #(
   parameter int MAX_WIDTH  = bts_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bts_pkg::MAX_HEIGHT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic [15:0]        req_texel_index,
   input  logic [15:0]        req_texel_value,
   input  logic [23:0]        req_sample_x,
   input  logic [23:0]        req_sample_y,
   output logic               rsp_valid,
   output logic signed [18:0] rsp_sample_value,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   bts_pkg::csr_type csr_ff, csr_in;
   bts_pkg::job_type push_job, head_job;
   logic             push, pop, full, empty;

   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bts_pkg::CSR_TEX_WIDTH:    csr_in.tex_width    = csr_wdata[8:0];
            bts_pkg::CSR_TEX_HEIGHT:   csr_in.tex_height   = csr_wdata[8:0];
            bts_pkg::CSR_WIDE_TEXELS:  csr_in.wide_texels  = csr_wdata[0];
            bts_pkg::CSR_RESOLUTION:   csr_in.resolution   = csr_wdata;
            bts_pkg::CSR_HORIZ_ANCHOR: csr_in.horiz_anchor = csr_wdata[1:0];
            bts_pkg::CSR_VERT_ANCHOR:  csr_in.vert_anchor  = csr_wdata[1:0];
            default:                   csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.tex_width    <= 9'd256;
         csr_ff.tex_height   <= 9'd256;
         csr_ff.wide_texels  <= 1'b1;
         csr_ff.resolution   <= '0;
         csr_ff.horiz_anchor <= bts_pkg::ANC_NEAR;
         csr_ff.vert_anchor  <= bts_pkg::ANC_NEAR;
      end else begin
         csr_ff <= csr_in;
      end
   end

   bts_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr             (csr_ff),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_texel_index (req_texel_index),
      .req_texel_value (req_texel_value),
      .req_sample_x    (req_sample_x),
      .req_sample_y    (req_sample_y),
      .push            (push),
      .push_job        (push_job),
      .full            (full)
   );

   bts_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (full),
      .empty    (empty)
   );

   bts_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr              (csr_ff),
      .head_job         (head_job),
      .empty            (empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_sample_value (rsp_sample_value)
   );

   // Results are spaced by a full sample's work
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back responses");

   // Front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue overflow");

   // Back never pops an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue underflow");

   // Block is ready right after reset
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> !busy) else $error("busy after reset");

endmodule
